FILE: rtl/svdi_pkg.sv
`timescale 1ns / 1ps

package svdi_pkg;

  localparam int STORED_POINTS = 41;

  localparam int DEPTH_W     = 23;  // input depth in metres
  localparam int VEL_W       = 20;  // velocity in 1e-5 km/s
  localparam int BP_W        = 22;  // breakpoint depth, up to 2891000 m
  localparam int OFF_W       = 17;  // offset inside a segment, spans are at most 100000 m
  localparam int DV_W        = 17;  // velocity step magnitude of a segment
  localparam int SLOPE_W     = 18;  // scaled slope, floor(dv * 2^SLOPE_SHIFT / span)
  localparam int SLOPE_SHIFT = 17;  // 2^17 > largest offset, so the estimate is off by at most one

  localparam int PROD_W = OFF_W + DV_W + 1;  // off * |dv| and qe * span
  localparam int QE_W   = SLOPE_W;
  localparam int SUM_W  = VEL_W + 2;

  typedef logic [BP_W-1:0]  bp_depth_t;
  typedef logic [VEL_W-1:0] vel_t;

  localparam bp_depth_t BP_DEPTH [STORED_POINTS] = '{
    22'd0,       22'd80000,   22'd115000,  22'd150000,  22'd185000,
    22'd220000,  22'd265000,  22'd310000,  22'd355000,  22'd410000,
    22'd450000,  22'd500000,  22'd550000,  22'd600000,  22'd635000,
    22'd660000,  22'd721000,  22'd771000,  22'd871000,  22'd971000,
    22'd1071000, 22'd1171000, 22'd1271000, 22'd1371000, 22'd1471000,
    22'd1571000, 22'd1671000, 22'd1771000, 22'd1871000, 22'd1971000,
    22'd2071000, 22'd2171000, 22'd2271000, 22'd2371000, 22'd2471000,
    22'd2571000, 22'd2671000, 22'd2741000, 22'd2771000, 22'd2871000,
    22'd2891000
  };

  localparam vel_t BP_VEL [STORED_POINTS] = '{
    20'd320000, 20'd447822, 20'd446909, 20'd445450, 20'd445468,
    20'd458160, 20'd468261, 20'd471424, 20'd474045, 20'd493808,
    20'd507616, 20'd522083, 20'd536300, 20'd550537, 20'd553107,
    20'd582747, 20'd608097, 20'd622689, 20'd629768, 20'd636628,
    20'd643242, 20'd649394, 20'd655343, 20'd661127, 20'd666472,
    20'd671700, 20'd676617, 20'd681436, 20'd686212, 20'd691058,
    20'd695355, 20'd699987, 20'd704128, 20'd708397, 20'd713106,
    20'd717435, 20'd721547, 20'd724654, 20'd724634, 20'd724546,
    20'd724526
  };

endpackage

FILE: rtl/shear_velocity_depth_interpolator.sv
`timescale 1ns / 1ps

// Piecewise linear shear velocity versus depth. Each request carries a depth in metres
// and returns one velocity in units of 1e-5 km/s, interpolated between the two table
// breakpoints that bracket the depth and rounded toward the lower breakpoint's velocity;
// a depth at or past the last breakpoint in use returns that breakpoint's velocity with
// beyond_table set. TABLE_POINTS selects how many leading breakpoints are used (2 to 41).
// The block takes one request per clock while in_stall_o is low, through a five-stage
// pipeline: breakpoint compares, segment lookup, slope and product multiplies, remainder
// multiply, and a final correct-and-add. A stall on the output holds the pipeline in
// place; bubbles close up so the input keeps flowing while slots are free.
module shear_velocity_depth_interpolator #(
  parameter int TABLE_POINTS = 41
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [22:0] depth_m_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [19:0] velocity_o,
  output logic        beyond_table_o
);

  localparam int NPTS  = (TABLE_POINTS > svdi_pkg::STORED_POINTS) ? svdi_pkg::STORED_POINTS :
                         ((TABLE_POINTS < 2) ? 2 : TABLE_POINTS);
  localparam int NSEG  = NPTS - 1;
  localparam int SEG_W = (NSEG > 1) ? $clog2(NSEG) : 1;

  localparam int OFF_W  = svdi_pkg::OFF_W;
  localparam int DV_W   = svdi_pkg::DV_W;
  localparam int SL_W   = svdi_pkg::SLOPE_W;
  localparam int PROD_W = svdi_pkg::PROD_W;
  localparam int QE_W   = svdi_pkg::QE_W;
  localparam int SUM_W  = svdi_pkg::SUM_W;
  localparam int VEL_W  = svdi_pkg::VEL_W;
  localparam int DEP_W  = svdi_pkg::DEPTH_W;

  localparam svdi_pkg::vel_t LAST_VEL = svdi_pkg::BP_VEL[NPTS-1];

  // per-segment constants, worked out at elaboration
  svdi_pkg::bp_depth_t seg_depth [NSEG];
  svdi_pkg::vel_t      seg_vel   [NSEG];
  logic [OFF_W-1:0]    seg_span  [NSEG];
  logic [DV_W-1:0]     seg_dvm   [NSEG];
  logic                seg_neg   [NSEG];
  logic [SL_W-1:0]     seg_slope [NSEG];

  for (genvar g = 0; g < NSEG; g++) begin : g_seg
    localparam logic [63:0] D_LO  = 64'(svdi_pkg::BP_DEPTH[g]);
    localparam logic [63:0] D_HI  = 64'(svdi_pkg::BP_DEPTH[g+1]);
    localparam logic [63:0] V_LO  = 64'(svdi_pkg::BP_VEL[g]);
    localparam logic [63:0] V_HI  = 64'(svdi_pkg::BP_VEL[g+1]);
    localparam logic [63:0] SPAN  = D_HI - D_LO;
    localparam logic        NEG   = (V_HI < V_LO);
    localparam logic [63:0] DVM   = NEG ? (V_LO - V_HI) : (V_HI - V_LO);
    localparam logic [63:0] SLOPE = (DVM << svdi_pkg::SLOPE_SHIFT) / SPAN;
    assign seg_depth[g] = svdi_pkg::BP_DEPTH[g];
    assign seg_vel[g]   = svdi_pkg::BP_VEL[g];
    assign seg_span[g]  = SPAN[OFF_W-1:0];
    assign seg_dvm[g]   = DVM[DV_W-1:0];
    assign seg_neg[g]   = NEG;
    assign seg_slope[g] = SLOPE[SL_W-1:0];
  end

  // pipeline advance, back to front
  logic s1_v_q, s2_v_q, s3_v_q, s4_v_q, out_v_q;
  logic adv_s1, adv_s2, adv_s3, adv_s4, adv_out;

  assign adv_out    = !out_v_q || !out_stall_i;
  assign adv_s4     = !s4_v_q || adv_out;
  assign adv_s3     = !s3_v_q || adv_s4;
  assign adv_s2     = !s2_v_q || adv_s3;
  assign adv_s1     = !s1_v_q || adv_s2;
  assign in_stall_o = !adv_s1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      s4_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (adv_s1) begin
        s1_v_q <= in_valid_i;
      end
      if (adv_s2) begin
        s2_v_q <= s1_v_q;
      end
      if (adv_s3) begin
        s3_v_q <= s2_v_q;
      end
      if (adv_s4) begin
        s4_v_q <= s3_v_q;
      end
      if (adv_out) begin
        out_v_q <= s4_v_q;
      end
    end
  end

  // stage 1: compare against every breakpoint in use past the first
  logic [DEP_W-1:0] s1_depth_q;
  logic [NPTS-1:1]  s1_ge_q, s1_ge_d;

  always_comb begin
    for (int i = 1; i < NPTS; i++) begin
      s1_ge_d[i] = (depth_m_i >= DEP_W'(svdi_pkg::BP_DEPTH[i]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_s1 && in_valid_i) begin
      s1_depth_q <= depth_m_i;
      s1_ge_q    <= s1_ge_d;
    end
  end

  // stage 2: pick the segment and look up its constants
  logic [SEG_W-1:0]    s2_seg;
  logic [DEP_W-1:0]    s2_off_full;
  logic [OFF_W-1:0]    s2_off_q;
  logic [DV_W-1:0]     s2_dvm_q;
  logic                s2_neg_q;
  logic [SL_W-1:0]     s2_slope_q;
  logic [OFF_W-1:0]    s2_span_q;
  svdi_pkg::vel_t      s2_vlo_q;
  logic                s2_beyond_q;

  always_comb begin
    s2_seg = '0;
    // thermometer edge: last breakpoint at or below the depth
    for (int g = 1; g < NSEG; g++) begin
      if (s1_ge_q[g] && !s1_ge_q[g+1]) begin
        s2_seg = SEG_W'(g);
      end
    end
  end

  assign s2_off_full = s1_depth_q - DEP_W'(seg_depth[s2_seg]);

  always_ff @(posedge clk_i) begin
    if (adv_s2 && s1_v_q) begin
      s2_off_q    <= s2_off_full[OFF_W-1:0];
      s2_dvm_q    <= seg_dvm[s2_seg];
      s2_neg_q    <= seg_neg[s2_seg];
      s2_slope_q  <= seg_slope[s2_seg];
      s2_span_q   <= seg_span[s2_seg];
      s2_vlo_q    <= seg_vel[s2_seg];
      s2_beyond_q <= s1_ge_q[NPTS-1];
    end
  end

  // stage 3: exact product and quotient estimate from the scaled slope
  logic [OFF_W+SL_W-1:0] s3_est_full;
  logic [PROD_W-1:0]     s3_prod_q;
  logic [QE_W-1:0]       s3_qe_q;
  logic [OFF_W-1:0]      s3_span_q;
  logic                  s3_neg_q;
  svdi_pkg::vel_t        s3_vlo_q;
  logic                  s3_beyond_q;

  assign s3_est_full = (OFF_W+SL_W)'(s2_off_q) * (OFF_W+SL_W)'(s2_slope_q);

  always_ff @(posedge clk_i) begin
    if (adv_s3 && s2_v_q) begin
      s3_prod_q   <= PROD_W'(s2_off_q) * PROD_W'(s2_dvm_q);
      s3_qe_q     <= QE_W'(s3_est_full >> svdi_pkg::SLOPE_SHIFT);
      s3_span_q   <= s2_span_q;
      s3_neg_q    <= s2_neg_q;
      s3_vlo_q    <= s2_vlo_q;
      s3_beyond_q <= s2_beyond_q;
    end
  end

  // stage 4: back-multiply the estimate for the remainder
  logic [PROD_W-1:0] s4_prod_q;
  logic [PROD_W-1:0] s4_back_q;
  logic [QE_W-1:0]   s4_qe_q;
  logic [OFF_W-1:0]  s4_span_q;
  logic              s4_neg_q;
  svdi_pkg::vel_t    s4_vlo_q;
  logic              s4_beyond_q;

  always_ff @(posedge clk_i) begin
    if (adv_s4 && s3_v_q) begin
      s4_prod_q   <= s3_prod_q;
      s4_back_q   <= PROD_W'(s3_qe_q) * PROD_W'(s3_span_q);
      s4_qe_q     <= s3_qe_q;
      s4_span_q   <= s3_span_q;
      s4_neg_q    <= s3_neg_q;
      s4_vlo_q    <= s3_vlo_q;
      s4_beyond_q <= s3_beyond_q;
    end
  end

  // stage 5: the estimate is low by at most one, fix it and add to the base
  logic [PROD_W-1:0]       out_rem;
  logic [QE_W-1:0]         out_quot;
  logic signed [SUM_W-1:0] out_sum;
  svdi_pkg::vel_t          out_vel_d;
  svdi_pkg::vel_t          out_vel_q;
  logic                    out_beyond_q;

  always_comb begin
    out_rem  = s4_prod_q - s4_back_q;
    out_quot = s4_qe_q + QE_W'(out_rem >= PROD_W'(s4_span_q));
    if (s4_neg_q) begin
      out_sum = $signed(SUM_W'(s4_vlo_q)) - $signed(SUM_W'(out_quot));
    end else begin
      out_sum = $signed(SUM_W'(s4_vlo_q)) + $signed(SUM_W'(out_quot));
    end
    if (s4_beyond_q) begin
      out_vel_d = LAST_VEL;
    end else if (out_sum < 0) begin
      out_vel_d = '0;
    end else if (out_sum > $signed(SUM_W'({VEL_W{1'b1}}))) begin
      out_vel_d = '1;
    end else begin
      out_vel_d = out_sum[VEL_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_out && s4_v_q) begin
      out_vel_q    <= out_vel_d;
      out_beyond_q <= s4_beyond_q;
    end
  end

  assign out_valid_o    = out_v_q;
  assign velocity_o     = out_vel_q;
  assign beyond_table_o = out_beyond_q;

endmodule
